FILE: hdl/jfp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jfp_pkg
// Shared types, constants and helpers of the Julia test-pattern block.
// ----------------------------------------------------------------------------
package jfp_pkg;

  localparam int unsigned CoordBits = 12;
  localparam int unsigned FracBits  = 28;
  localparam int unsigned MaxIter   = 64;
  localparam int unsigned DimW      = 13;
  localparam int unsigned CW        = 30;
  localparam int unsigned ZW        = 32;
  localparam int unsigned SatW      = 48;
  localparam int unsigned DivNumW   = CoordBits + FracBits;
  localparam int unsigned DivDenW   = DimW;
  localparam int unsigned IterW     = $clog2(MaxIter + 1);
  localparam int unsigned RampNumW  = CoordBits + 8;

  localparam logic [2*ZW:0] EscLimit = (2*ZW+1)'(4) << (2*FracBits);

  typedef enum logic [1:0] {
    TAG_X  = 2'd0,
    TAG_Y  = 2'd1,
    TAG_CB = 2'd2,
    TAG_CR = 2'd3
  } jfp_tag_e;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_C_RE   = 2'd2,
    REG_C_IM   = 2'd3
  } jfp_reg_e;

  typedef struct packed {
    logic [CoordBits-1:0] col;
    logic [CoordBits-1:0] pixel_row;
  } jfp_in_t;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] cb_value;
    logic [7:0] cr_value;
    logic       chroma_site;
  } jfp_out_t;

  // One division request as it moves down the cell row.
  typedef struct packed {
    logic               valid;
    jfp_tag_e           tag;
    logic [DivDenW-1:0] rem;
    logic [DivNumW-1:0] num;
    logic [DivDenW-1:0] den;
  } jfp_div_t;

  function automatic logic signed [ZW-1:0] sat32(input logic signed [SatW-1:0] v);
    logic [SatW-ZW:0] hi;
    hi = v[SatW-1:ZW-1];
    if ((&hi) || !(|hi)) begin
      return v[ZW-1:0];
    end else if (v[SatW-1]) begin
      return {1'b1, {(ZW-1){1'b0}}};
    end else begin
      return {1'b0, {(ZW-1){1'b1}}};
    end
  endfunction

endpackage
`default_nettype wire

FILE: hdl/jfp_div_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jfp_div_cell
// One restoring-division step: brings in one dividend bit, emits one
// quotient bit, registers the request for the next cell.
// ----------------------------------------------------------------------------
module jfp_div_cell import jfp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  jfp_div_t cell_i,
  output jfp_div_t cell_o
);

  logic [DivDenW:0]   trial;
  logic               qbit;
  logic [DivDenW:0]   sub;
  logic [DivDenW-1:0] rem_d;
  logic               valid_q;
  jfp_tag_e           tag_q;
  logic [DivDenW-1:0] rem_q;
  logic [DivNumW-1:0] num_q;
  logic [DivDenW-1:0] den_q;

  always_comb begin
    trial = {cell_i.rem, cell_i.num[DivNumW-1]};
    qbit  = trial >= {1'b0, cell_i.den};
    sub   = trial - {1'b0, cell_i.den};
    rem_d = qbit ? sub[DivDenW-1:0] : trial[DivDenW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q <= cell_i.tag;
    rem_q <= rem_d;
    num_q <= {cell_i.num[DivNumW-2:0], qbit};
    den_q <= cell_i.den;
  end

  assign cell_o = '{valid: valid_q, tag: tag_q, rem: rem_q, num: num_q, den: den_q};

endmodule
`default_nettype wire

FILE: hdl/jfp_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jfp_divider
// Row of division cells, one quotient bit per cell; takes a request
// every cycle and registers it in each cell on its way to the output.
// ----------------------------------------------------------------------------
module jfp_divider import jfp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  jfp_div_t div_i,
  output jfp_div_t div_o
);

  jfp_div_t link [DivNumW+1];

  assign link[0] = div_i;

  for (genvar g = 0; g < DivNumW; g++) begin : g_cell
    jfp_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (link[g]),
      .cell_o (link[g+1])
    );
  end

  assign div_o = link[DivNumW];

endmodule
`default_nettype wire

FILE: hdl/jfp_escape.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jfp_escape
// Escape-time iteration z = z*z + c; each step has a multiply phase,
// then an escape test and update phase.
// ----------------------------------------------------------------------------
module jfp_escape import jfp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [ZW-1:0] x0_i,
  input  logic signed [ZW-1:0] y0_i,
  input  logic signed [CW-1:0] c_re_i,
  input  logic signed [CW-1:0] c_im_i,
  output logic                 done_o,
  output logic [7:0]           luma_o
);

  logic                   busy_q;
  logic                   phase_q;
  logic [IterW-1:0]       k_q;
  logic signed [ZW-1:0]   x_q, y_q;
  logic signed [2*ZW-1:0] xx_q, yy_q, xy_q;
  logic                   done_q;
  logic [7:0]             luma_q;

  logic [2*ZW:0]          mag;
  logic signed [2*ZW:0]   dsq;
  logic signed [SatW-1:0] re_w, im_w;
  logic                   escaped;
  logic [IterW-1:0]       km1;

  always_comb begin
    mag     = {1'b0, xx_q} + {1'b0, yy_q};
    escaped = (k_q != '0) && (mag > EscLimit);
    dsq     = $signed({xx_q[2*ZW-1], xx_q}) - $signed({yy_q[2*ZW-1], yy_q});
    re_w    = SatW'(dsq >>> FracBits) + SatW'(c_re_i);
    im_w    = SatW'(xy_q >>> (FracBits - 1)) + SatW'(c_im_i);
    km1     = k_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
      k_q     <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        phase_q <= 1'b0;
        k_q     <= '0;
      end else if (busy_q && !phase_q) begin
        phase_q <= 1'b1;
      end else if (busy_q) begin
        phase_q <= 1'b0;
        if (escaped || k_q == IterW'(MaxIter)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          k_q <= k_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= x0_i;
      y_q <= y0_i;
    end else if (busy_q && !phase_q) begin
      xx_q <= x_q * x_q;
      yy_q <= y_q * y_q;
      xy_q <= x_q * y_q;
    end else if (busy_q) begin
      if (escaped) begin
        luma_q <= 8'({km1, 2'b00});
      end else if (k_q == IterW'(MaxIter)) begin
        luma_q <= 8'hff;
      end else begin
        x_q <= sat32(re_w);
        y_q <= sat32(im_w);
      end
    end
  end

  assign done_o = done_q;
  assign luma_o = luma_q;

endmodule
`default_nettype wire

FILE: hdl/julia_fractal_test_pattern.sv
`default_nettype none
// ----------------------------------------------------------------------------
// julia_fractal_test_pattern
// Julia-set escape-time luma plus chroma ramps, one pixel per request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one pixel
//   request {col, pixel_row}. Output channel (out_valid_o / out_stall_i /
//   out_data_o) returns {luma, cb_value, cr_value, chroma_site} per request.
//   A request moves at a clock edge with valid high and stall low.
//   Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (0 width, 1 height, 2 c_re, 3 c_im); write only while idle.
// Timing:
//   One pixel at a time. After acceptance, four divisions enter the cell
//   row one after another; the row is 40 cells deep. Once the last
//   quotient is back, the escape loop runs its iterations (multiply, then
//   test/update) until z escapes or the iteration count reaches MaxIter;
//   the escape loop sets the throughput.
// Reset clears control and restores the register defaults (640x480,
// c = 0 + 0.78i). A stalled result is held in the output register while
// the next request is already taken and computed.
// ----------------------------------------------------------------------------
module julia_fractal_test_pattern import jfp_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  jfp_in_t        in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output jfp_out_t       out_data_o,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [CW-1:0]  cfg_data_i
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_FEED = 5'b00010,
    S_DIV  = 5'b00100,
    S_ESC  = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [DimW-1:0]      width_q, height_q;
  logic signed [CW-1:0] c_re_q, c_im_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimW'(640);
      height_q <= DimW'(480);
      c_re_q   <= '0;
      c_im_q   <= CW'(209379655);
    end else if (cfg_we_i) begin
      unique case (jfp_reg_e'(cfg_idx_i))
        REG_WIDTH:  width_q  <= cfg_data_i[DimW-1:0];
        REG_HEIGHT: height_q <= cfg_data_i[DimW-1:0];
        REG_C_RE:   c_re_q   <= cfg_data_i;
        REG_C_IM:   c_im_q   <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // Held request and intermediate results
  jfp_in_t              req_q;
  logic [1:0]           feed_q;
  logic signed [ZW-1:0] x0_q, y0_q;
  logic [7:0]           cb_q, cr_q, luma_q;
  logic                 out_valid_q;
  jfp_out_t             out_q;
  logic                 site;
  logic                 slot_free;

  assign site      = !req_q.col[0] && !req_q.pixel_row[0];
  assign slot_free = !out_valid_q || !out_stall_i;

  // Division requests: two start coordinates, then two chroma ramps
  jfp_div_t div_in, div_out;
  logic [RampNumW-1:0] ramp_col, ramp_row;

  always_comb begin
    ramp_col = {1'b0, req_q.col[CoordBits-1:1], 8'b0}
             - RampNumW'(req_q.col[CoordBits-1:1]);
    ramp_row = {1'b0, req_q.pixel_row[CoordBits-1:1], 8'b0}
             - RampNumW'(req_q.pixel_row[CoordBits-1:1]);
    div_in       = '0;
    div_in.valid = (state_q == S_FEED);
    div_in.tag   = jfp_tag_e'(feed_q);
    unique case (jfp_tag_e'(feed_q))
      TAG_X: begin
        div_in.num = {req_q.col, {FracBits{1'b0}}};
        div_in.den = (width_q == '0) ? DimW'(1) : width_q;
      end
      TAG_Y: begin
        div_in.num = {req_q.pixel_row, {FracBits{1'b0}}};
        div_in.den = (height_q == '0) ? DimW'(1) : height_q;
      end
      TAG_CB: begin
        div_in.num = DivNumW'(ramp_col);
        div_in.den = {1'b0, width_q[DimW-1:1]};
      end
      TAG_CR: begin
        div_in.num = DivNumW'(ramp_row);
        div_in.den = {1'b0, height_q[DimW-1:1]};
      end
      default: ;
    endcase
  end

  jfp_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .div_i  (div_in),
    .div_o  (div_out)
  );

  // Post-process quotients: 5 * (q - 0.5) saturated, ramp clipped to 255
  logic signed [DivNumW+1:0] qd;
  logic signed [SatW-1:0]    q5;
  logic signed [ZW-1:0]      zstart;
  logic [7:0]                ramp8;
  logic                      esc_start;

  always_comb begin
    qd     = $signed({2'b00, div_out.num})
           - $signed((DivNumW+2)'(2 ** (FracBits - 1)));
    q5     = (SatW'(qd) <<< 2) + SatW'(qd);
    zstart = sat32(q5);
    if (div_out.den == '0) begin
      ramp8 = 8'd0;
    end else if (|div_out.num[DivNumW-1:8]) begin
      ramp8 = 8'hff;
    end else begin
      ramp8 = div_out.num[7:0];
    end
  end

  assign esc_start = (state_q == S_DIV) && div_out.valid && (div_out.tag == TAG_CR);

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      req_q <= in_data_i;
    end
    if (state_q == S_DIV && div_out.valid) begin
      unique case (div_out.tag)
        TAG_X:   x0_q <= zstart;
        TAG_Y:   y0_q <= zstart;
        TAG_CB:  cb_q <= ramp8;
        TAG_CR:  cr_q <= ramp8;
        default: ;
      endcase
    end
  end

  logic       esc_done;
  logic [7:0] esc_luma;

  jfp_escape u_esc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (esc_start),
    .x0_i    (x0_q),
    .y0_i    (y0_q),
    .c_re_i  (c_re_q),
    .c_im_i  (c_im_q),
    .done_o  (esc_done),
    .luma_o  (esc_luma)
  );

  always_ff @(posedge clk_i) begin
    if (state_q == S_ESC && esc_done) begin
      luma_q <= esc_luma;
    end
    if (state_q == S_DONE && slot_free) begin
      out_q.luma        <= luma_q;
      out_q.cb_value    <= site ? cb_q : 8'd0;
      out_q.cr_value    <= site ? cr_q : 8'd0;
      out_q.chroma_site <= site;
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_FEED;
      S_FEED: if (feed_q == 2'(TAG_CR)) state_d = S_DIV;
      S_DIV:  if (esc_start) state_d = S_ESC;
      S_ESC:  if (esc_done) state_d = S_DONE;
      S_DONE: if (slot_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      feed_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_FEED) begin
        feed_q <= feed_q + 1'b1;
      end else begin
        feed_q <= '0;
      end
      // Load a finished pixel when the slot frees up; drop valid on take
      if (state_q == S_DONE && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Quotients only come back while the sequencer waits for them
  a_div_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_out.valid |-> (state_q == S_DIV))
    else $error("division result outside wait state");

  // Escape engine finishes only while it is being waited on
  a_esc_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_done |-> (state_q == S_ESC))
    else $error("escape done outside escape state");

  // A finished pixel with a free slot shows up as valid next cycle
  a_load_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && slot_free) |=> (out_valid_q && state_q == S_IDLE))
    else $error("finished pixel not presented");

endmodule
`default_nettype wire

FILE: verif/tb_julia_fractal_test_pattern.sv
// ----------------------------------------------------------------------------
// tb_julia_fractal_test_pattern
// Self-checking bench: drives pixel requests under random idling and stalls,
// predicts luma/chroma in Q4.28 fixed point, and compares every result.
// ----------------------------------------------------------------------------
module tb_julia_fractal_test_pattern import jfp_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdleLimit = 4000;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid_i = 1'b0;
  logic           in_stall_o;
  jfp_in_t        in_data_i = '0;
  logic           out_valid_o;
  logic           out_stall_i = 1'b0;
  jfp_out_t       out_data_o;
  logic           cfg_we_i = 1'b0;
  logic [1:0]     cfg_idx_i = '0;
  logic [CW-1:0]  cfg_data_i = '0;

  julia_fractal_test_pattern u_top (.*);

  always #5 clk_i = ~clk_i;

  // Shadow copy of the configuration registers
  logic [DimW-1:0]       width_q  = 13'd640;
  logic [DimW-1:0]       height_q = 13'd480;
  logic signed [63:0]    c_re_q   = 0;
  logic signed [63:0]    c_im_q   = 64'sd209379655;

  jfp_out_t pixel_q[$];
  int       err_cnt = 0;
  int       idle_cnt = 0;
  bit       calm = 1'b0;  // long stretch with no idling on either side

  function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic signed [63:0] start_point(input logic [11:0] pos,
                                                      input logic [DimW-1:0] size);
    logic [63:0] d;
    logic signed [63:0] q;
    d = (size == 0) ? 64'd1 : 64'(size);
    q = $signed((64'(pos) << FracBits) / d);
    return clamp32(5 * (q - (64'sd1 <<< (FracBits - 1))));
  endfunction

  function automatic logic [7:0] ramp_value(input logic [11:0] pos,
                                            input logic [DimW-1:0] size);
    logic [63:0] half, v;
    half = 64'(size >> 1);
    if (half == 0) return 8'd0;
    v = (64'(pos >> 1) * 255) / half;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  // Escape time plus chroma ramps for one pixel
  function automatic jfp_out_t predict_pixel(input jfp_in_t px);
    jfp_out_t r;
    logic signed [63:0] x, y, nr, ni;
    logic [63:0] mag;
    bit site;
    x = start_point(px.col, width_q);
    y = start_point(px.pixel_row, height_q);
    r.luma = 8'hff;
    for (int i = 0; i < MaxIter; i++) begin
      nr = ((x * x - y * y) >>> FracBits) + c_re_q;
      ni = ((x * y) >>> (FracBits - 1)) + c_im_q;
      x = clamp32(nr);
      y = clamp32(ni);
      mag = 64'(x * x) + 64'(y * y);
      if (mag > (64'd4 << 56)) begin
        r.luma = 8'(i * 4);
        break;
      end
    end
    site = !px.col[0] && !px.pixel_row[0];
    r.cb_value = site ? ramp_value(px.col, width_q) : 8'd0;
    r.cr_value = site ? ramp_value(px.pixel_row, height_q) : 8'd0;
    r.chroma_site = site;
    return r;
  endfunction

  // Drive the result-side stall at random
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 16);
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      jfp_out_t want;
      if (pixel_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result %h", out_data_o);
      end else begin
        want = pixel_q.pop_front();
        if (want.luma !== out_data_o.luma || want.cb_value !== out_data_o.cb_value ||
            want.cr_value !== out_data_o.cr_value ||
            want.chroma_site !== out_data_o.chroma_site) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch: expected luma %0d cb %0d cr %0d site %0d, got %0d %0d %0d %0d",
                     want.luma, want.cb_value, want.cr_value, want.chroma_site,
                     out_data_o.luma, out_data_o.cb_value, out_data_o.cr_value,
                     out_data_o.chroma_site);
        end
      end
    end
  end

  // Watchdog: count cycles with no request moving on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt > IdleLimit) begin
      $display("[julia_fractal_test_pattern] ERROR");
      $finish;
    end
  end

  // Hold one request until taken; idle at random beforehand.
  // Valid stays high after the take so back-to-back requests need no gap.
  task automatic send_pixel(input int c, input int r);
    jfp_in_t px;
    px.col = 12'(c);
    px.pixel_row = 12'(r);
    while (!calm && ($urandom_range(99) < 16)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= px;
    pixel_q.push_back(predict_pixel(px));
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drop valid and drain all results
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(input jfp_reg_e idx, input logic [CW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_WIDTH:  width_q = val[DimW-1:0];
      REG_HEIGHT: height_q = val[DimW-1:0];
      REG_C_RE:   c_re_q = 64'(signed'(val));
      REG_C_IM:   c_im_q = 64'(signed'(val));
      default: ;
    endcase
  endtask

  task automatic set_frame(input int w, input int h, input int cr, input int ci);
    wait_drained();
    write_reg(REG_WIDTH, CW'(w));
    write_reg(REG_HEIGHT, CW'(h));
    write_reg(REG_C_RE, CW'(cr));
    write_reg(REG_C_IM, CW'(ci));
    cfg_we_i <= 1'b0;
  endtask

  // Directed: corners, parity, beyond-frame and register defaults, then tiny, zero-width and 4096-wide frames
  task automatic test_directed();
    send_pixel(0, 0);
    send_pixel(639, 479);
    send_pixel(320, 240);
    send_pixel(1, 0);
    send_pixel(0, 1);
    send_pixel(4095, 4095);
    send_pixel(4094, 4094);
    send_pixel(12'haaa, 12'h555);
    set_frame(2, 2, -268435456, 268435456);
    send_pixel(0, 0);
    send_pixel(1, 1);
    send_pixel(4094, 2);
    set_frame(0, 1, 268435456, -268435456);
    send_pixel(0, 0);
    send_pixel(2, 4094);
    set_frame(4096, 4096, 0, 0);
    send_pixel(4095, 0);
    send_pixel(2048, 2048);
    send_pixel(4094, 4094);
  endtask

  // Random: mostly in-frame pixels, some beyond the frame; a new frame every 100 pixels
  task automatic test_random(input int n);
    int w, h;
    for (int k = 0; k < n; k++) begin
      if (k % 100 == 0) begin
        w = (k % 300 == 0) ? $urandom_range(4096, 2) : $urandom_range(64, 2);
        h = $urandom_range(4096, 2);
        set_frame(w, h, $urandom_range(536870912) - 268435456,
                  $urandom_range(536870912) - 268435456);
        calm = (k == 300);
      end
      if ($urandom_range(9) == 0) send_pixel($urandom, $urandom);
      else send_pixel($urandom_range(w - 1), $urandom_range(h - 1));
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(700);
    wait_drained();
    if (err_cnt == 0) begin
      $display("[julia_fractal_test_pattern] OK");
    end else begin
      $display("[julia_fractal_test_pattern] ERROR");
    end
    $finish;
  end

endmodule
